// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Widths, stage numbers and types shared by the line/sphere intersection core.
// ----------------------------------------------------------------------------
package lsi_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int RAD_W     = COORD_W - 1;
	localparam int TOL_W     = 40;
	localparam logic [TOL_W-1:0] TOL_RESET = 40'd4295;
	localparam int TOL_SHIFT = 4 * FRAC_W - 32;

	localparam int Q_W    = COORD_W + 1;        // p - s
	localparam int DD_W   = 2 * COORD_W;        // d*d
	localparam int DQ_W   = COORD_W + Q_W;      // d*q
	localparam int QQ_W   = 2 * Q_W - 1;        // q*q, unsigned
	localparam int RR_W   = 2 * RAD_W;          // r*r
	localparam int A_W    = DD_W;               // |d|^2
	localparam int H_W    = DQ_W + 1;           // d.q
	localparam int C_W    = QQ_W + 2;           // |q|^2 - r^2, signed
	localparam int E_W    = 4 * COORD_W + 4;    // h^2 - a(c - r^2)
	localparam int ROOT_W = E_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int K_W    = ROOT_W + 2;         // +-sqrt - h
	localparam int NUM_W  = COORD_W + K_W;      // d*k
	localparam int N_W    = NUM_W + 1;          // 2|num| + a
	localparam int D_W    = A_W + 1;            // 2a
	localparam int QB     = COORD_W + 2;        // quotient bits kept before saturation
	localparam int SUM_W  = QB + 2;

	// chunked multiplier
	localparam int MUL_W  = K_W + 2;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MCH_W  = 24;
	localparam int MCH_N  = (MUL_W + MCH_W - 1) / MCH_W;
	localparam int MMAG_W = MCH_N * MCH_W;
	localparam int ROW_W  = MMAG_W + MCH_W;

	// pipeline stage numbers (register index after acceptance)
	localparam int LAT_MUL = 5;
	localparam int LAT_DIV = QB + 2;
	localparam int ST_SUM  = 3;
	localparam int ST_HH   = ST_SUM + LAT_MUL;
	localparam int ST_E    = ST_HH + 1;
	localparam int ST_CLS  = ST_E + 1;
	localparam int ST_ROOT = ST_CLS + ROOT_W;
	localparam int ST_K    = ST_ROOT + 1;
	localparam int ST_DN   = ST_K + LAT_MUL;
	localparam int ST_DV   = ST_DN + LAT_DIV;
	localparam int ST_OUT  = ST_DV + 1;

	typedef logic [2:0][COORD_W-1:0] vec3_t;

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_TWO  = 2'd2
	} cnt_t;

	typedef struct packed {
		cnt_t  cnt;
		vec3_t first;
		vec3_t second;
		logic  degen;
	} out_t;

endpackage

// File: rtl/lsi_mul.sv
// ----------------------------------------------------------------------------
// lsi_mul
// Signed multiplier, sign-magnitude, 24x24 partial products, five stages.
// ----------------------------------------------------------------------------
module lsi_mul (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [lsi_pkg::MUL_W-1:0]  op_a,
	input  logic signed [lsi_pkg::MUL_W-1:0]  op_b,
	output logic signed [lsi_pkg::PROD_W-1:0] prod
);

	logic [lsi_pkg::MMAG_W-1:0]   ma_s1, mb_s1;
	logic                         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*lsi_pkg::MCH_W-1:0]  pp_s2 [lsi_pkg::MCH_N][lsi_pkg::MCH_N];
	logic [lsi_pkg::ROW_W-1:0]    row_c [lsi_pkg::MCH_N];
	logic [lsi_pkg::ROW_W-1:0]    row_s3 [lsi_pkg::MCH_N];
	logic [2*lsi_pkg::MMAG_W-1:0] mag_c, mag_s4;
	logic signed [lsi_pkg::PROD_W-1:0] prod_s5;

	always_comb begin
		for (int i = 0; i < lsi_pkg::MCH_N; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < lsi_pkg::MCH_N; j++)
				row_c[i] = row_c[i] + (lsi_pkg::ROW_W'(pp_s2[i][j]) << (j * lsi_pkg::MCH_W));
		end
		mag_c = '0;
		for (int i = 0; i < lsi_pkg::MCH_N; i++)
			mag_c = mag_c + ((2*lsi_pkg::MMAG_W)'(row_s3[i]) << (i * lsi_pkg::MCH_W));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= lsi_pkg::MMAG_W'($unsigned(op_a[lsi_pkg::MUL_W-1] ? -op_a : op_a));
			mb_s1  <= lsi_pkg::MMAG_W'($unsigned(op_b[lsi_pkg::MUL_W-1] ? -op_b : op_b));
			neg_s1 <= op_a[lsi_pkg::MUL_W-1] ^ op_b[lsi_pkg::MUL_W-1];
			for (int i = 0; i < lsi_pkg::MCH_N; i++)
				for (int j = 0; j < lsi_pkg::MCH_N; j++)
					pp_s2[i][j] <= ma_s1[i*lsi_pkg::MCH_W +: lsi_pkg::MCH_W]
						* mb_s1[j*lsi_pkg::MCH_W +: lsi_pkg::MCH_W];
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			mag_s4 <= mag_c;
			neg_s4 <= neg_s3;
			prod_s5 <= neg_s4 ? -$signed(lsi_pkg::PROD_W'(mag_s4))
				: $signed(lsi_pkg::PROD_W'(mag_s4));
		end
	end

	assign prod = prod_s5;

endmodule

// File: rtl/lsi_div.sv
// ----------------------------------------------------------------------------
// lsi_div
// base + round(num / den), ties away from zero, saturated to the coordinate
// range. Restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsi_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [lsi_pkg::NUM_W-1:0]  num,
	input  logic [lsi_pkg::A_W-1:0]           den,
	input  logic signed [lsi_pkg::COORD_W-1:0] base,
	output logic signed [lsi_pkg::COORD_W-1:0] res
);

	localparam logic signed [lsi_pkg::COORD_W-1:0] CMAX = {1'b0, {(lsi_pkg::COORD_W-1){1'b1}}};
	localparam logic signed [lsi_pkg::COORD_W-1:0] CMIN = {1'b1, {(lsi_pkg::COORD_W-1){1'b0}}};

	logic [lsi_pkg::N_W-1:0]            rem_s  [0:lsi_pkg::QB];
	logic [lsi_pkg::QB-1:0]             quo_s  [0:lsi_pkg::QB];
	logic [lsi_pkg::D_W-1:0]            den_s  [0:lsi_pkg::QB];
	logic                               neg_s  [0:lsi_pkg::QB];
	logic                               ovf_s  [0:lsi_pkg::QB];
	logic signed [lsi_pkg::COORD_W-1:0] base_s [0:lsi_pkg::QB];
	logic signed [lsi_pkg::COORD_W-1:0] res_s;

	logic [lsi_pkg::NUM_W-1:0] mag;
	logic [lsi_pkg::N_W-1:0]   nn;
	logic [lsi_pkg::D_W-1:0]   dd;
	logic signed [lsi_pkg::SUM_W-1:0] off, sum;

	always_comb begin
		mag = $unsigned(num[lsi_pkg::NUM_W-1] ? -num : num);
		nn  = {mag, 1'b0} + lsi_pkg::N_W'(den);
		dd  = {den, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= nn;
			quo_s[0]  <= '0;
			den_s[0]  <= dd;
			neg_s[0]  <= num[lsi_pkg::NUM_W-1];
			ovf_s[0]  <= nn >= (lsi_pkg::N_W'(dd) << lsi_pkg::QB);
			base_s[0] <= base;
		end
	end

	genvar g;
	for (g = 0; g < lsi_pkg::QB; g++) begin : g_step
		logic [lsi_pkg::N_W-1:0] cmp;
		logic                    take;
		assign cmp  = lsi_pkg::N_W'(den_s[g]) << (lsi_pkg::QB - 1 - g);
		assign take = rem_s[g] >= cmp;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? rem_s[g] - cmp : rem_s[g];
				quo_s[g+1]  <= {quo_s[g][lsi_pkg::QB-2:0], take};
				den_s[g+1]  <= den_s[g];
				neg_s[g+1]  <= neg_s[g];
				ovf_s[g+1]  <= ovf_s[g];
				base_s[g+1] <= base_s[g];
			end
		end
	end

	always_comb begin
		off = neg_s[lsi_pkg::QB] ? -$signed(lsi_pkg::SUM_W'(quo_s[lsi_pkg::QB]))
			: $signed(lsi_pkg::SUM_W'(quo_s[lsi_pkg::QB]));
		sum = lsi_pkg::SUM_W'(base_s[lsi_pkg::QB]) + off;
	end

	// quotient too large for the kept bits: result is pinned by sign alone
	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[lsi_pkg::QB])
				res_s <= neg_s[lsi_pkg::QB] ? CMIN : CMAX;
			else if (sum > lsi_pkg::SUM_W'(CMAX))
				res_s <= CMAX;
			else if (sum < lsi_pkg::SUM_W'(CMIN))
				res_s <= CMIN;
			else
				res_s <= lsi_pkg::COORD_W'(sum);
		end
	end

	assign res = res_s;

endmodule

// File: rtl/line_sphere_intersection_core.sv
// Throughput: one item per cycle while the skid register is empty; the
// 66-stage square root and the 34-step dividers are fully pipelined, so
// nothing iterates.
// A result not taken is parked in a one-entry skid register; the pipeline
// stalls as a whole only while that register is full.
// Reset clears all valid bits and the skid; tolerance returns to 4295.
// ----------------------------------------------------------------------------
// line_sphere_intersection_core
// Fixed-point line/sphere intersection: discriminant, tangent test, square
// root and the two rounded, saturated intersection points.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_sphere_intersection_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lsi_pkg::TOL_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [lsi_pkg::COORD_W-1:0] centre_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] centre_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] centre_z,
	input  logic [lsi_pkg::RAD_W-1:0]          sphere_radius,
	input  logic signed [lsi_pkg::COORD_W-1:0] point_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] point_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] point_z,
	input  logic signed [lsi_pkg::COORD_W-1:0] dir_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] dir_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] dir_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         hit_count,
	output logic signed [lsi_pkg::COORD_W-1:0] first_x,
	output logic signed [lsi_pkg::COORD_W-1:0] first_y,
	output logic signed [lsi_pkg::COORD_W-1:0] first_z,
	output logic signed [lsi_pkg::COORD_W-1:0] second_x,
	output logic signed [lsi_pkg::COORD_W-1:0] second_y,
	output logic signed [lsi_pkg::COORD_W-1:0] second_z,
	output logic                               degenerate
);

	logic [lsi_pkg::TOL_W-1:0] tol_q;
	logic                      en;
	logic                      vld [1:lsi_pkg::ST_OUT];
	lsi_pkg::out_t             out_s119, skid_q, out_sel;
	logic                      skid_vld_q;

	// data lines
	lsi_pkg::vec3_t                  p_dl [1:lsi_pkg::ST_DN];
	lsi_pkg::vec3_t                  d_dl [1:lsi_pkg::ST_K];
	logic [lsi_pkg::A_W-1:0]         a_dl [lsi_pkg::ST_SUM:lsi_pkg::ST_DN];
	logic signed [lsi_pkg::H_W-1:0]  h_dl [lsi_pkg::ST_SUM:lsi_pkg::ST_ROOT];
	logic                            degen_dl [lsi_pkg::ST_SUM+1:lsi_pkg::ST_OUT-1];
	lsi_pkg::cnt_t                   cnt_dl [lsi_pkg::ST_CLS:lsi_pkg::ST_DV];

	logic signed [lsi_pkg::Q_W-1:0]  q_s1 [3];
	logic [lsi_pkg::RAD_W-1:0]       rad_s1;
	logic signed [lsi_pkg::DD_W-1:0] dd_s2 [3];
	logic signed [lsi_pkg::DQ_W-1:0] dq_s2 [3];
	logic [lsi_pkg::QQ_W-1:0]        qq_s2 [3];
	logic [lsi_pkg::RR_W-1:0]        rr_s2;
	logic signed [lsi_pkg::C_W-1:0]  cr_s3;

	logic signed [lsi_pkg::PROD_W-1:0] hh, acr;
	logic signed [lsi_pkg::E_W-1:0]    e_s9;
	logic [lsi_pkg::E_W-1:0]           abs_e;
	logic                              tang;
	lsi_pkg::cnt_t                     cnt_c;

	logic [lsi_pkg::REM_W-1:0]  sq_rem  [0:lsi_pkg::ROOT_W];
	logic [lsi_pkg::ROOT_W-1:0] sq_root [0:lsi_pkg::ROOT_W];
	logic [lsi_pkg::E_W-1:0]    sq_x    [0:lsi_pkg::ROOT_W];

	logic signed [lsi_pkg::K_W-1:0]    kp_s77, km_s77;
	logic signed [lsi_pkg::PROD_W-1:0] pp_prod [3];
	logic signed [lsi_pkg::PROD_W-1:0] pm_prod [3];
	logic signed [lsi_pkg::COORD_W-1:0] rp [3];
	logic signed [lsi_pkg::COORD_W-1:0] rm [3];

	assign cfg_ready = 1'b1;
	assign en        = !skid_vld_q;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= lsi_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= lsi_pkg::ST_OUT; k++)
				vld[k] <= 1'b0;
		end else if (en) begin
			vld[1] <= in_valid;
			for (int k = 2; k <= lsi_pkg::ST_OUT; k++)
				vld[k] <= vld[k-1];
		end
	end

	// stages 1-3: q = p - s, products, sums
	always_ff @(posedge clk) begin
		if (en) begin
			p_dl[1]   <= {point_z, point_y, point_x};
			d_dl[1]   <= {dir_z, dir_y, dir_x};
			q_s1[0]   <= lsi_pkg::Q_W'(point_x) - lsi_pkg::Q_W'(centre_x);
			q_s1[1]   <= lsi_pkg::Q_W'(point_y) - lsi_pkg::Q_W'(centre_y);
			q_s1[2]   <= lsi_pkg::Q_W'(point_z) - lsi_pkg::Q_W'(centre_z);
			rad_s1    <= sphere_radius;
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= lsi_pkg::DD_W'($signed(d_dl[1][i]))
					* lsi_pkg::DD_W'($signed(d_dl[1][i]));
				dq_s2[i] <= lsi_pkg::DQ_W'($signed(d_dl[1][i])) * lsi_pkg::DQ_W'(q_s1[i]);
				qq_s2[i] <= lsi_pkg::QQ_W'(lsi_pkg::DQ_W'(q_s1[i]) * lsi_pkg::DQ_W'(q_s1[i]));
			end
			rr_s2 <= lsi_pkg::RR_W'(rad_s1) * lsi_pkg::RR_W'(rad_s1);
			a_dl[lsi_pkg::ST_SUM] <= lsi_pkg::A_W'(dd_s2[0]) + lsi_pkg::A_W'(dd_s2[1])
				+ lsi_pkg::A_W'(dd_s2[2]);
			h_dl[lsi_pkg::ST_SUM] <= lsi_pkg::H_W'(dq_s2[0]) + lsi_pkg::H_W'(dq_s2[1])
				+ lsi_pkg::H_W'(dq_s2[2]);
			cr_s3 <= $signed(lsi_pkg::C_W'(qq_s2[0]) + lsi_pkg::C_W'(qq_s2[1])
				+ lsi_pkg::C_W'(qq_s2[2]) - lsi_pkg::C_W'(rr_s2));
			degen_dl[lsi_pkg::ST_SUM+1] <= (a_dl[lsi_pkg::ST_SUM] == '0);
			for (int k = 2; k <= lsi_pkg::ST_DN; k++)
				p_dl[k] <= p_dl[k-1];
			for (int k = 2; k <= lsi_pkg::ST_K; k++)
				d_dl[k] <= d_dl[k-1];
			for (int k = lsi_pkg::ST_SUM + 1; k <= lsi_pkg::ST_DN; k++)
				a_dl[k] <= a_dl[k-1];
			for (int k = lsi_pkg::ST_SUM + 1; k <= lsi_pkg::ST_ROOT; k++)
				h_dl[k] <= h_dl[k-1];
			for (int k = lsi_pkg::ST_SUM + 2; k <= lsi_pkg::ST_OUT - 1; k++)
				degen_dl[k] <= degen_dl[k-1];
		end
	end

	// h^2 and a(c - r^2)
	lsi_mul u_mul_hh (
		.clk  (clk),
		.en   (en),
		.op_a (lsi_pkg::MUL_W'(h_dl[lsi_pkg::ST_SUM])),
		.op_b (lsi_pkg::MUL_W'(h_dl[lsi_pkg::ST_SUM])),
		.prod (hh)
	);

	lsi_mul u_mul_acr (
		.clk  (clk),
		.en   (en),
		.op_a ($signed(lsi_pkg::MUL_W'(a_dl[lsi_pkg::ST_SUM]))),
		.op_b (lsi_pkg::MUL_W'(cr_s3)),
		.prod (acr)
	);

	// classification; tolerance compares |4e| against tol shifted to e's scale
	always_comb begin
		abs_e = $unsigned(e_s9[lsi_pkg::E_W-1] ? -e_s9 : e_s9);
		tang  = {abs_e, 2'b00} < ((lsi_pkg::E_W+2)'(tol_q) << lsi_pkg::TOL_SHIFT);
		if (degen_dl[lsi_pkg::ST_E])
			cnt_c = lsi_pkg::CNT_NONE;
		else if (tang)
			cnt_c = lsi_pkg::CNT_ONE;
		else if (e_s9[lsi_pkg::E_W-1])
			cnt_c = lsi_pkg::CNT_NONE;
		else
			cnt_c = lsi_pkg::CNT_TWO;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s9 <= lsi_pkg::E_W'(hh - acr);
			cnt_dl[lsi_pkg::ST_CLS] <= cnt_c;
			for (int k = lsi_pkg::ST_CLS + 1; k <= lsi_pkg::ST_DV; k++)
				cnt_dl[k] <= cnt_dl[k-1];
			// tangent and miss feed zero, so tangent uses k = -h
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_x[0]    <= (cnt_c == lsi_pkg::CNT_TWO) ? $unsigned(e_s9) : '0;
		end
	end

	// digit-by-digit square root, one result bit per stage
	genvar g;
	for (g = 0; g < lsi_pkg::ROOT_W; g++) begin : g_sqrt
		logic [lsi_pkg::REM_W+1:0] trial, sub;
		logic                      take;
		assign trial = {sq_rem[g], sq_x[g][lsi_pkg::E_W-1 -: 2]};
		assign sub   = (lsi_pkg::REM_W+2)'({sq_root[g], 2'b01});
		assign take  = trial >= sub;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem[g+1]  <= take ? lsi_pkg::REM_W'(trial - sub) : lsi_pkg::REM_W'(trial);
				sq_root[g+1] <= {sq_root[g][lsi_pkg::ROOT_W-2:0], take};
				sq_x[g+1]    <= {sq_x[g][lsi_pkg::E_W-3:0], 2'b00};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kp_s77 <= $signed({2'b00, sq_root[lsi_pkg::ROOT_W]})
				- lsi_pkg::K_W'(h_dl[lsi_pkg::ST_ROOT]);
			km_s77 <= -$signed({2'b00, sq_root[lsi_pkg::ROOT_W]})
				- lsi_pkg::K_W'(h_dl[lsi_pkg::ST_ROOT]);
		end
	end

	for (g = 0; g < 3; g++) begin : g_axis
		lsi_mul u_mul_p (
			.clk  (clk),
			.en   (en),
			.op_a (lsi_pkg::MUL_W'($signed(d_dl[lsi_pkg::ST_K][g]))),
			.op_b (lsi_pkg::MUL_W'(kp_s77)),
			.prod (pp_prod[g])
		);
		lsi_mul u_mul_m (
			.clk  (clk),
			.en   (en),
			.op_a (lsi_pkg::MUL_W'($signed(d_dl[lsi_pkg::ST_K][g]))),
			.op_b (lsi_pkg::MUL_W'(km_s77)),
			.prod (pm_prod[g])
		);
		lsi_div u_div_p (
			.clk  (clk),
			.en   (en),
			.num  (lsi_pkg::NUM_W'(pp_prod[g])),
			.den  (a_dl[lsi_pkg::ST_DN]),
			.base ($signed(p_dl[lsi_pkg::ST_DN][g])),
			.res  (rp[g])
		);
		lsi_div u_div_m (
			.clk  (clk),
			.en   (en),
			.num  (lsi_pkg::NUM_W'(pm_prod[g])),
			.den  (a_dl[lsi_pkg::ST_DN]),
			.base ($signed(p_dl[lsi_pkg::ST_DN][g])),
			.res  (rm[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s119.cnt   <= cnt_dl[lsi_pkg::ST_DV];
			out_s119.degen <= degen_dl[lsi_pkg::ST_OUT-1];
			for (int i = 0; i < 3; i++) begin
				out_s119.first[i]  <= (cnt_dl[lsi_pkg::ST_DV] != lsi_pkg::CNT_NONE) ? rp[i] : '0;
				out_s119.second[i] <= (cnt_dl[lsi_pkg::ST_DV] == lsi_pkg::CNT_TWO) ? rm[i] : '0;
			end
		end
	end

	// skid: catches the last stage when the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready)
				skid_vld_q <= 1'b0;
		end else if (vld[lsi_pkg::ST_OUT] && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld[lsi_pkg::ST_OUT] && !out_ready)
			skid_q <= out_s119;
	end

	assign out_sel    = skid_vld_q ? skid_q : out_s119;
	assign out_valid  = skid_vld_q | vld[lsi_pkg::ST_OUT];
	assign hit_count  = out_sel.cnt;
	assign first_x    = out_sel.first[0];
	assign first_y    = out_sel.first[1];
	assign first_z    = out_sel.first[2];
	assign second_x   = out_sel.second[0];
	assign second_y   = out_sel.second[1];
	assign second_z   = out_sel.second[2];
	assign degenerate = out_sel.degen;

	`ASSERT_IMPLIES(a_degen_no_hit, out_valid && degenerate, hit_count == lsi_pkg::CNT_NONE, "degenerate transaction reports hits")
	`ASSERT_IMPLIES(a_second_zero, out_valid && hit_count != lsi_pkg::CNT_TWO, second_x == '0 && second_y == '0 && second_z == '0, "second point set without two hits")
	`ASSERT_NEXT(a_skid_fill, vld[lsi_pkg::ST_OUT] && en && !out_ready, skid_vld_q, "stalled result not parked in skid")

endmodule

// File: sim/line_sphere_intersection_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_sphere_intersection_checker
// Watches the input, output and tolerance channels of the intersection core,
// predicts each result with wide exact arithmetic and compares field by field.
// ----------------------------------------------------------------------------
module line_sphere_intersection_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [lsi_pkg::TOL_W-1:0]          cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [lsi_pkg::COORD_W-1:0] centre_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] centre_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] centre_z,
	input  logic [lsi_pkg::RAD_W-1:0]          sphere_radius,
	input  logic signed [lsi_pkg::COORD_W-1:0] point_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] point_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] point_z,
	input  logic signed [lsi_pkg::COORD_W-1:0] dir_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] dir_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] dir_z,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [1:0]                         hit_count,
	input  logic signed [lsi_pkg::COORD_W-1:0] first_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] first_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] first_z,
	input  logic signed [lsi_pkg::COORD_W-1:0] second_x,
	input  logic signed [lsi_pkg::COORD_W-1:0] second_y,
	input  logic signed [lsi_pkg::COORD_W-1:0] second_z,
	input  logic                               degenerate,
	output int                                 errors,
	output int                                 pending,
	output int                                 hits_seen [3],
	output int                                 degen_seen
);

	typedef logic signed [255:0] wint_t;

	logic [lsi_pkg::TOL_W-1:0] tolerance;
	lsi_pkg::out_t             hit_queue [$];

	function automatic wint_t abs_w(input wint_t v);
		return (v < 0) ? -v : v;
	endfunction

	// nearest, ties away from zero; den > 0
	function automatic wint_t div_round(input wint_t num, input wint_t den);
		wint_t q;
		q = (2 * abs_w(num) + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic [lsi_pkg::COORD_W-1:0] clamp_coord(input wint_t v);
		if (v > wint_t'(32'sh7fffffff)) return 32'h7fffffff;
		if (v < -wint_t'(64'sh80000000)) return 32'h80000000;
		return v[lsi_pkg::COORD_W-1:0];
	endfunction

	function automatic wint_t floor_sqrt(input wint_t x);
		logic [255:0] root, cand;
		root = '0;
		for (int k = 127; k >= 0; k--) begin
			cand = root | (256'd1 << k);
			if (cand * cand <= x) root = cand;
		end
		return root;
	endfunction

	function automatic lsi_pkg::out_t solve_line_sphere(input lsi_pkg::vec3_t cs,
			input logic [lsi_pkg::RAD_W-1:0] rad, input lsi_pkg::vec3_t ps,
			input lsi_pkg::vec3_t ds, input logic [lsi_pkg::TOL_W-1:0] tol);
		lsi_pkg::out_t r;
		wint_t pw [3];
		wint_t dw [3];
		wint_t qw, a, h, c, rr, e, thr, rw, root, kp, km;
		r = '0;
		a = 0;
		h = 0;
		c = 0;
		for (int i = 0; i < 3; i++) begin
			pw[i] = $signed(ps[i]);
			dw[i] = $signed(ds[i]);
			qw = pw[i] - wint_t'($signed(cs[i]));
			a += dw[i] * dw[i];
			h += dw[i] * qw;
			c += qw * qw;
		end
		if (a == 0) begin
			r.degen = 1'b1;
			return r;
		end
		rw  = {225'd0, rad};
		rr  = rw * rw;
		e   = h * h - a * (c - rr);
		thr = {216'd0, tol} <<< lsi_pkg::TOL_SHIFT;
		// tolerance is tested ahead of the sign, so a slightly negative e is a tangent
		if ((abs_w(e) <<< 2) < thr) begin
			r.cnt = lsi_pkg::CNT_ONE;
			for (int i = 0; i < 3; i++)
				r.first[i] = clamp_coord(pw[i] - div_round(dw[i] * h, a));
		end else if (e >= 0) begin
			root = floor_sqrt(e);
			kp = root - h;
			km = -root - h;
			r.cnt = lsi_pkg::CNT_TWO;
			for (int i = 0; i < 3; i++) begin
				r.first[i]  = clamp_coord(pw[i] + div_round(dw[i] * kp, a));
				r.second[i] = clamp_coord(pw[i] + div_round(dw[i] * km, a));
			end
		end
		return r;
	endfunction

	assign pending = hit_queue.size();

	// all inputs change only at the rising edge, so the falling edge sees the
	// values that the next rising edge will act on
	always @(negedge clk or negedge arst_n) begin
		lsi_pkg::out_t want, got;
		if (!arst_n) begin
			tolerance = lsi_pkg::TOL_RESET;
			hit_queue.delete();
			errors = 0;
			degen_seen = 0;
			for (int i = 0; i < 3; i++) hits_seen[i] = 0;
		end else begin
			if (cfg_valid && cfg_ready) tolerance = cfg_data;
			if (in_valid && in_ready)
				hit_queue.push_back(solve_line_sphere({centre_z, centre_y, centre_x},
					sphere_radius, {point_z, point_y, point_x}, {dir_z, dir_y, dir_x},
					tolerance));
			if (out_valid && out_ready) begin
				got.cnt    = lsi_pkg::cnt_t'(hit_count);
				got.first  = {first_z, first_y, first_x};
				got.second = {second_z, second_y, second_x};
				got.degen  = degenerate;
				if (hit_queue.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result transaction: %p", got);
				end else begin
					want = hit_queue.pop_front();
					if (want.cnt <= lsi_pkg::CNT_TWO) hits_seen[want.cnt]++;
					if (want.degen) degen_seen++;
					if (got.cnt !== want.cnt || got.first !== want.first ||
							got.second !== want.second || got.degen !== want.degen) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: cnt %0d/%0d degen %0b/%0b (exp/act)",
								want.cnt, got.cnt, want.degen, got.degen);
							$display("  first  exp %h act %h", want.first, got.first);
							$display("  second exp %h act %h", want.second, got.second);
						end
					end
				end
			end
		end
	end
endmodule

// File: sim/line_sphere_intersection_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_sphere_intersection_core_tb
// Drives directed and random line/sphere queries under several tolerance
// settings and backpressure profiles; the checker predicts and compares.
// ----------------------------------------------------------------------------
module line_sphere_intersection_core_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 140;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [lsi_pkg::TOL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic signed [lsi_pkg::COORD_W-1:0] centre_x = '0, centre_y = '0, centre_z = '0;
	logic [lsi_pkg::RAD_W-1:0] sphere_radius = '0;
	logic signed [lsi_pkg::COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic signed [lsi_pkg::COORD_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid, out_ready = 1'b0;
	logic [1:0] hit_count;
	logic signed [lsi_pkg::COORD_W-1:0] first_x, first_y, first_z;
	logic signed [lsi_pkg::COORD_W-1:0] second_x, second_y, second_z;
	logic degenerate;

	int errors, pending, degen_seen;
	int hits_seen [3];
	int tx_idle = 0, rx_idle = 0;
	int hold_reqs = 0, hold_done = 0, hold_left = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	line_sphere_intersection_core dut (.*);

	line_sphere_intersection_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("line_sphere_intersection_core_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_reqs != hold_done) begin
			hold_done++;
			hold_left = 600;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_query(input logic [31:0] cx, cy, cz, input logic [31:0] rad,
			input logic [31:0] px, py, pz, input logic [31:0] dx, dy, dz);
		logic ok;
		if ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		centre_x <= cx;
		centre_y <= cy;
		centre_z <= cz;
		sphere_radius <= rad[lsi_pkg::RAD_W-1:0];
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		dir_x <= dx;
		dir_y <= dy;
		dir_z <= dz;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [lsi_pkg::TOL_W-1:0] tol);
		logic ok;
		cfg_valid <= 1'b1;
		cfg_data <= tol;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] small_val(input int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	// mostly well-posed geometry, with tangents, zero directions and raw noise
	task automatic random_query();
		logic [31:0] cx, cy, cz, rad, px, py, pz, dx, dy, dz, off;
		int mode;
		mode = $urandom_range(99);
		cx = small_val(1 << 20);
		cy = small_val(1 << 20);
		cz = small_val(1 << 20);
		rad = $urandom_range(1 << 20);
		if (mode < 15) begin
			send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else if (mode < 25) begin
			// axis-aligned line at exactly one radius from the centre
			off = small_val(1 << 21);
			dx = small_val(1 << 18);
			if (dx == 0) dx = 1;
			send_query(cx, cy, cz, rad, cx + off, cy + rad, cz, dx, 0, 0);
		end else if (mode < 30) begin
			send_query(cx, cy, cz, rad, $urandom, $urandom, $urandom, 0, 0, 0);
		end else begin
			px = cx + small_val(1 << 21);
			py = cy + small_val(rad + 1);
			pz = cz + small_val(rad + 1);
			dx = small_val(1 << 18);
			dy = small_val(1 << 12);
			dz = small_val(1 << 12);
			send_query(cx, cy, cz, rad, px, py, pz, dx, dy, dz);
		end
	endtask

	logic [lsi_pkg::TOL_W-1:0] tol_plan [5];

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero direction, tangent, miss, secant
		send_query(0, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0);
		send_query(0, 0, 0, 32'h10000, 32'h20000, 0, 0, 32'h10000, 0, 0);
		send_query(0, 0, 0, 32'h10000, 32'h20000, 32'h10000, 0, 32'h10000, 0, 0);
		send_query(0, 0, 0, 32'h10000, 32'h20000, 32'h20000, 0, 32'h10000, 0, 0);
		send_query(0, 0, 0, 32'h10000, 32'h20000, 32'h0ffff, 0, 32'h10000, 0, 0);
		send_query(0, 0, 0, 32'h10000, 32'h20000, 32'h10001, 0, 32'h10000, 0, 0);
		send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
		send_query(0, 0, 0, 32'h7fffffff, 0, 0, 0, 1, 0, 0);
		send_query(0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 32'h80000000);
		send_query(0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
		send_query(0, 0, 0, 32'hffffffff, 32'h100, 0, 0, 0, 0, 1);
		send_query(32'h7fffffff, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 32'hffffffff, 0, 0);
		send_query(32'h12345, 32'h6789, 32'h1111, 32'h8000, 32'h12345, 32'h6789, 32'h1111,
			32'h3, 32'h5, 32'h7);
		send_query(0, 0, 0, 1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_query(32'h80000000, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h80000000, 1, 1);
		drain_results();

		tol_plan[0] = 40'hff_ffff_ffff;
		tol_plan[1] = '0;
		tol_plan[2] = lsi_pkg::TOL_W'({$urandom, $urandom});
		tol_plan[3] = lsi_pkg::TOL_RESET;
		tol_plan[4] = {8'h00, $urandom};
		for (int ph = 0; ph < 5; ph++) begin
			write_tolerance(tol_plan[ph]);
			tx_idle = (ph < 2) ? 16 : (ph < 4) ? 85 : 0;
			rx_idle = (ph < 2) ? 85 : (ph < 4) ? 16 : 0;
			for (int n = 0; n < 280; n++) begin
				random_query();
				if (ph == 4 && n == 40) hold_reqs++;
				if (n == 140) drain_results();
			end
			drain_results();
		end

		$display("covered %0d zero-direction, %0d miss, %0d tangent, %0d secant results",
			degen_seen, hits_seen[0] - degen_seen, hits_seen[1], hits_seen[2]);
		$display("over five tolerance settings with mixed backpressure and one long stall");
		if (errors == 0 && pending == 0) begin
			$display("line_sphere_intersection_core_tb: clean");
		end else begin
			$display("line_sphere_intersection_core_tb: errors");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/lsi_pkg.sv
rtl/lsi_mul.sv
rtl/lsi_div.sv
rtl/line_sphere_intersection_core.sv
sim/line_sphere_intersection_checker.sv
sim/line_sphere_intersection_core_tb.sv
